// File: design/sldf_pkg.sv
// shared types and constants for the sync/length/checksum deframer
package sldf_pkg;

   // frame parser phases
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   // request function codes
   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_VALUE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 1'd1;
   localparam int unsigned CSR_DATA_W = 16;

   // register reset values
   localparam logic [7:0]  SYNC_VALUE_RST  = 8'hA0;
   localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1020;

   // one result from the frame parser
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] index;
      logic [15:0] frame_length;
   } result_type;

endpackage

// File: design/sldf_if.sv
// request and response channel interfaces of the deframer
interface sldf_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface sldf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  out_data;
   logic [15:0] out_index;
   logic [15:0] frame_length;

   modport source (output valid, output out_kind, output out_data, output out_index,
                   output frame_length, input ready);
   modport sink (input valid, input out_kind, input out_data, input out_index,
                 input frame_length, output ready);
endinterface

// File: design/sldf_frame_fsm.sv
// frame parser: phase machine, length, byte count and running sum
module sldf_frame_fsm
   import sldf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        func,
   input  logic [7:0]  rx_byte,
   input  logic [7:0]  sync_value,
   input  logic [15:0] max_payload,
   output result_type  result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;

   logic [15:0] len_word;
   logic [15:0] count_inc;
   logic [7:0]  sum_add;
   logic        too_long;

   // shared datapath terms
   assign len_word  = {len_ff[15:8], rx_byte};
   assign count_inc = count_ff + 16'd1;
   assign sum_add   = sum_ff + rx_byte;
   assign too_long  = (len_word > max_payload);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (func == FUNC_CLEAR) begin
            phase_in = PH_HUNT;
         end else begin
            unique case (phase_ff)
               PH_LEN_HI: phase_in = PH_LEN_LO;
               PH_LEN_LO: begin
                  if (too_long)
                     phase_in = PH_HUNT;
                  else if (len_word == 16'd0)
                     phase_in = PH_CHECK;
                  else
                     phase_in = PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  if (count_inc >= len_ff)
                     phase_in = PH_CHECK;
               end
               PH_CHECK: phase_in = PH_HUNT;
               default: begin
                  if (rx_byte == sync_value)
                     phase_in = PH_LEN_HI;
                  else
                     phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   // length, count and sum updates
   always_comb begin
      len_in   = len_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (step) begin
         if (func == FUNC_CLEAR) begin
            len_in   = '0;
            count_in = '0;
            sum_in   = '0;
         end else begin
            unique case (phase_ff)
               PH_LEN_HI: begin
                  len_in = {rx_byte, 8'h00};
                  sum_in = sum_add;
               end
               PH_LEN_LO: begin
                  count_in = '0;
                  if (too_long) begin
                     len_in = '0;
                     sum_in = '0;
                  end else begin
                     len_in = len_word;
                     sum_in = sum_add;
                  end
               end
               PH_PAYLOAD: begin
                  count_in = count_inc;
                  sum_in   = sum_add;
               end
               PH_CHECK: begin
                  len_in   = '0;
                  count_in = '0;
                  sum_in   = '0;
               end
               default: begin
                  len_in   = '0;
                  count_in = '0;
                  sum_in   = (rx_byte == sync_value) ? rx_byte : 8'h00;
               end
            endcase
         end
      end
   end

   // result for the current byte
   always_comb begin
      result              = '0;
      result.kind         = KIND_DATA;
      if (step && (func == FUNC_BYTE)) begin
         unique case (phase_ff)
            PH_LEN_LO: begin
               if (too_long) begin
                  result.valid        = 1'b1;
                  result.kind         = KIND_BAD;
                  result.frame_length = len_word;
               end
            end
            PH_PAYLOAD: begin
               result.valid        = 1'b1;
               result.kind         = KIND_DATA;
               result.data         = rx_byte;
               result.index        = count_ff;
               result.frame_length = len_ff;
            end
            PH_CHECK: begin
               result.valid        = 1'b1;
               result.kind         = (sum_ff == rx_byte) ? KIND_GOOD : KIND_BAD;
               result.frame_length = len_ff;
            end
            default: begin
               result.valid = 1'b0;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         len_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // a data result always lies inside its frame
   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.kind == KIND_DATA) |-> result.index < result.frame_length)
      else $error("payload index outside frame length");

   // a clear request always returns to hunting with the state zeroed
   a_clear_hunts: assert property (@(posedge clock) disable iff (reset)
      step && (func == FUNC_CLEAR) |=> (phase_ff == PH_HUNT) && (sum_ff == 8'h00)
         && (len_ff == 16'd0))
      else $error("clear did not restart hunting");

   // payload phase never holds a zero length
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (len_ff != 16'd0) && (count_ff < len_ff))
      else $error("payload phase with empty or finished frame");

endmodule

// File: design/sync_length_checksum_deframer_core.sv
// Deframer for a received serial byte stream: hunts for the sync byte, decodes a big-endian
// 16-bit length, passes each payload byte out with its index and then reports the frame good
// or bad from an 8-bit additive checksum over sync, length and payload; a length above
// max_payload is reported bad right after the header. One request is taken every clock cycle
// unless the response side stalls; each request goes through an input register, the parser
// logic and a result register, which offers the response. Requests that give no response
// (hunting, header bytes, clear) still pass through the parser. The result register stalls
// only when the response side holds ready low. The user must write the registers through
// the csr port only while the block is idle; the block itself does not enforce this.
module sync_length_checksum_deframer_core
   import sldf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   sldf_req_if.sink               req_if,
   sldf_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [7:0]  sync_byte_ff;
   logic [15:0] max_payload_ff;

   logic        in_valid_ff;
   logic        in_func_ff;
   logic [7:0]  in_byte_ff;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  result;

   logic        advance;
   logic        req_take;

   // parser runs when the result register is free or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff   <= SYNC_VALUE_RST;
         max_payload_ff <= MAX_PAYLOAD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_VALUE:  sync_byte_ff   <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_if.func;
         in_byte_ff <= req_if.rx_byte;
      end
   end

   // frame parser
   sldf_frame_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .func        (in_func_ff),
      .rx_byte     (in_byte_ff),
      .sync_value  (sync_byte_ff),
      .max_payload (max_payload_ff),
      .result      (result)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance)
         out_valid_in = result.valid;
      else if (rsp_if.ready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.out_kind     = out_ff.kind;
   assign rsp_if.out_data     = out_ff.data;
   assign rsp_if.out_index    = out_ff.index;
   assign rsp_if.frame_length = out_ff.frame_length;

endmodule

// File: sim/tb_sync_length_checksum_deframer_core.sv
// testbench for the sync/length/checksum deframer: directed frames, then random traffic
`timescale 1ns / 100ps

module tb_sync_length_checksum_deframer_core;
   import sldf_pkg::*;

   localparam int unsigned CLOCK_HALF      = 5;
   localparam int unsigned PHASE_ITEMS     = 115;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned PRESSURE_AFTER  = 150;
   localparam int unsigned PRESSURE_CYCLES = 80;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned PRINT_LIMIT     = 50;

   // one response of the deframer
   typedef struct {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] index;
      logic [15:0] flen;
   } parser_output_type;

   // one row of the directed table
   typedef struct {
      bit                typed;
      logic              func;
      logic [7:0]        rx;
      bit                has_rsp;
      parser_output_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sldf_req_if req_ch ();
   sldf_rsp_if rsp_ch ();

   sync_length_checksum_deframer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mirror of the parser state and registers
   phase_type   parse_phase;
   logic [15:0] hdr_length;
   logic [15:0] payload_count;
   logic [7:0]  sum_acc;
   logic [7:0]  cfg_sync;
   logic [15:0] cfg_max;

   parser_output_type parsed_outputs[$];
   stim_row_type      directed_rows[$];

   int unsigned mismatches;
   int unsigned requests_sent;
   int unsigned responses_seen;
   int unsigned good_frames;
   int unsigned bad_frames;
   int unsigned settings_applied;
   int unsigned idle_cycles;
   bit          sender_steady;
   bit          receiver_steady;
   bit          pressure_done;

   always #CLOCK_HALF clock = ~clock;

   // deframer mirror: returns the response caused by one request, if any
   function automatic void parse_rx(input logic f, input logic [7:0] b,
                                    output logic produced, output parser_output_type res);
      produced = 1'b0;
      res = '{KIND_DATA, 8'h00, 16'h0000, 16'h0000};
      if (f == FUNC_CLEAR) begin
         parse_phase = PH_HUNT;
         hdr_length = '0;
         payload_count = '0;
         sum_acc = '0;
      end else begin
         case (parse_phase)
            PH_LEN_HI: begin
               hdr_length = {b, 8'h00};
               sum_acc = sum_acc + b;
               parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               hdr_length = hdr_length | {8'h00, b};
               sum_acc = sum_acc + b;
               payload_count = '0;
               if (hdr_length > cfg_max) begin
                  produced = 1'b1;
                  res = '{KIND_BAD, 8'h00, 16'h0000, hdr_length};
                  parse_phase = PH_HUNT;
                  hdr_length = '0;
                  sum_acc = '0;
               end else begin
                  parse_phase = (hdr_length == 16'd0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               produced = 1'b1;
               res = '{KIND_DATA, b, payload_count, hdr_length};
               sum_acc = sum_acc + b;
               payload_count = payload_count + 16'd1;
               if (payload_count >= hdr_length) parse_phase = PH_CHECK;
            end
            PH_CHECK: begin
               produced = 1'b1;
               res = '{(sum_acc == b) ? KIND_GOOD : KIND_BAD, 8'h00, 16'h0000, hdr_length};
               parse_phase = PH_HUNT;
               hdr_length = '0;
               payload_count = '0;
               sum_acc = '0;
            end
            default: begin
               parse_phase = PH_HUNT;
               hdr_length = '0;
               payload_count = '0;
               sum_acc = '0;
               if (b == cfg_sync) begin
                  sum_acc = b;
                  parse_phase = PH_LEN_HI;
               end
            end
         endcase
      end
   endfunction

   function automatic int unsigned draw_gap(input bit steady);
      return steady ? 0 : $urandom_range(10);
   endfunction

   function automatic void add_row(input bit typed, input logic f, input logic [7:0] b,
                                   input bit has_rsp, input kind_type k, input logic [7:0] d,
                                   input logic [15:0] idx, input logic [15:0] len);
      stim_row_type row;
      row.typed = typed;
      row.func = f;
      row.rx = b;
      row.has_rsp = has_rsp;
      row.want = '{k, d, idx, len};
      directed_rows.push_back(row);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at %0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // offer one request after a random gap and wait until it is taken
   task automatic send_request(input logic f, input logic [7:0] b);
      int unsigned gap;
      gap = draw_gap(sender_steady);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic offer(input logic f, input logic [7:0] b);
      logic produced;
      parser_output_type res;
      send_request(f, b);
      parse_rx(f, b, produced, res);
      if (produced) parsed_outputs.push_back(res);
      requests_sent++;
   endtask

   // wait until every response is in and the parser has gone quiet
   task automatic settle_idle();
      req_ch.valid <= 1'b0;
      while (parsed_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] sync_byte, input logic [15:0] limit);
      csr_we <= 1'b1;
      csr_index <= CSR_SYNC_VALUE;
      csr_wdata <= {8'h00, sync_byte};
      @(posedge clock);
      cfg_sync = sync_byte;
      csr_index <= CSR_MAX_PAYLOAD;
      csr_wdata <= limit;
      @(posedge clock);
      cfg_max = limit;
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // mostly well-formed frames with random content, some noise, clears and broken frames
   task automatic send_random_traffic(input int unsigned quota);
      int unsigned taken;
      int unsigned pick;
      int unsigned i;
      logic [15:0] len;
      bit          abort;
      taken = 0;
      while (taken < quota) begin
         pick = $urandom_range(99);
         if ($urandom_range(7) == 0) sender_steady = !sender_steady;
         if (pick < 10) begin
            // line noise, mostly dropped while hunting
            repeat ($urandom_range(4, 1)) offer(FUNC_BYTE, 8'($urandom_range(255)));
         end else if (pick < 16) begin
            offer(FUNC_CLEAR, 8'($urandom_range(255)));
            taken++;
         end else begin
            if (parse_phase != PH_HUNT && $urandom_range(1) == 1) begin
               offer(FUNC_CLEAR, 8'($urandom_range(255)));
               taken++;
            end
            // pick a payload length: over the limit, at the limit, or short
            if (pick < 24 && cfg_max != 16'hFFFF)
               len = 16'($urandom_range(65535, cfg_max + 1));
            else if (pick < 30 && cfg_max <= 16'd40)
               len = cfg_max;
            else
               len = 16'($urandom_range((cfg_max < 16'd12) ? cfg_max : 16'd12));
            abort = ($urandom_range(19) == 0);
            offer(FUNC_BYTE, cfg_sync);
            offer(FUNC_BYTE, len[15:8]);
            offer(FUNC_BYTE, len[7:0]);
            taken += 3;
            for (i = 0; i < len && parse_phase == PH_PAYLOAD; i++) begin
               offer(FUNC_BYTE, ($urandom_range(9) == 0) ? cfg_sync : 8'($urandom_range(255)));
               taken++;
            end
            // trailing checksum, sometimes corrupted, sometimes replaced by a clear
            if (parse_phase == PH_CHECK) begin
               if (abort)
                  offer(FUNC_CLEAR, 8'($urandom_range(255)));
               else if ($urandom_range(4) == 0)
                  offer(FUNC_BYTE, sum_acc ^ 8'($urandom_range(255, 1)));
               else
                  offer(FUNC_BYTE, sum_acc);
               taken++;
            end
         end
      end
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      int unsigned gap;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!pressure_done && responses_seen >= PRESSURE_AFTER) begin
            rsp_ch.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
         end
         gap = draw_gap(receiver_steady);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if ($urandom_range(15) == 0) receiver_steady = !receiver_steady;
      end
   end

   // response check and watchdog
   always @(posedge clock) begin : response_check
      parser_output_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            responses_seen++;
            if (rsp_ch.out_kind == KIND_GOOD) good_frames++;
            else if (rsp_ch.out_kind == KIND_BAD) bad_frames++;
            if (parsed_outputs.size() == 0) begin
               report_mismatch("response with nothing pending, out_kind",
                               32'(rsp_ch.out_kind), 0);
            end else begin
               want = parsed_outputs.pop_front();
               if (rsp_ch.out_kind !== want.kind)
                  report_mismatch("out_kind", 32'(rsp_ch.out_kind), 32'(want.kind));
               if (rsp_ch.out_data !== want.data)
                  report_mismatch("out_data", 32'(rsp_ch.out_data), 32'(want.data));
               if (rsp_ch.out_index !== want.index)
                  report_mismatch("out_index", 32'(rsp_ch.out_index), 32'(want.index));
               if (rsp_ch.frame_length !== want.flen)
                  report_mismatch("frame_length", 32'(rsp_ch.frame_length), 32'(want.flen));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: %0d cycles with no transfer", idle_cycles);
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic              produced;
      parser_output_type res;
      int unsigned       p;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_BYTE;
      req_ch.rx_byte = 8'h00;
      csr_we = 1'b0;
      csr_index = CSR_SYNC_VALUE;
      csr_wdata = '0;
      mismatches = 0;
      requests_sent = 0;
      responses_seen = 0;
      good_frames = 0;
      bad_frames = 0;
      settings_applied = 0;
      idle_cycles = 0;
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      pressure_done = 1'b0;
      cfg_sync = SYNC_VALUE_RST;
      cfg_max = MAX_PAYLOAD_RST;
      parse_phase = PH_HUNT;
      hdr_length = '0;
      payload_count = '0;
      sum_acc = '0;

      // directed frames at the reset register values
      add_row(1, FUNC_BYTE,  8'h55, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);   // noise while hunting
      add_row(1, FUNC_BYTE,  8'hA0, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);   // zero-length frame
      add_row(1, FUNC_BYTE,  8'h00, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'h00, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'hA0, 1, KIND_GOOD, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'hA0, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);   // two bytes, sync inside
      add_row(1, FUNC_BYTE,  8'h00, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'h02, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'hFF, 1, KIND_DATA, 8'hFF, 16'd0, 16'd2);
      add_row(1, FUNC_BYTE,  8'hA0, 1, KIND_DATA, 8'hA0, 16'd1, 16'd2);
      add_row(1, FUNC_BYTE,  8'h41, 1, KIND_GOOD, 8'h00, 16'd0, 16'd2);
      add_row(1, FUNC_BYTE,  8'hA0, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);   // bad checksum
      add_row(1, FUNC_BYTE,  8'h00, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'h01, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'h00, 1, KIND_DATA, 8'h00, 16'd0, 16'd1);
      add_row(1, FUNC_BYTE,  8'h00, 1, KIND_BAD,  8'h00, 16'd0, 16'd1);
      add_row(1, FUNC_BYTE,  8'hA0, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);   // one over the limit
      add_row(1, FUNC_BYTE,  8'h03, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'hFD, 1, KIND_BAD,  8'h00, 16'd0, 16'd1021);
      add_row(0, FUNC_BYTE,  8'hA0, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);   // exactly the limit
      add_row(0, FUNC_BYTE,  8'h03, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(0, FUNC_BYTE,  8'hFC, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(0, FUNC_BYTE,  8'h7E, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_CLEAR, 8'hFF, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);   // clear mid-frame
      add_row(1, FUNC_BYTE,  8'hA0, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);   // largest length
      add_row(1, FUNC_BYTE,  8'hFF, 0, KIND_DATA, 8'h00, 16'd0, 16'd0);
      add_row(1, FUNC_BYTE,  8'hFF, 1, KIND_BAD,  8'h00, 16'd0, 16'd65535);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table: typed rows push their own result, the rest use the mirror
      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].func, directed_rows[r].rx);
         parse_rx(directed_rows[r].func, directed_rows[r].rx, produced, res);
         if (directed_rows[r].typed) begin
            if (directed_rows[r].has_rsp) parsed_outputs.push_back(directed_rows[r].want);
         end else if (produced) begin
            parsed_outputs.push_back(res);
         end
         requests_sent++;
      end

      // random traffic under several register settings, extremes included
      for (p = 0; p < 6; p++) begin
         settle_idle();
         case (p)
            1: apply_settings(8'h00, 16'd0);
            2: apply_settings(8'hFF, 16'hFFFF);
            3: apply_settings(8'($urandom_range(255)), 16'($urandom_range(15)));
            4: apply_settings(8'($urandom_range(255)), 16'($urandom_range(65535)));
            5: apply_settings(SYNC_VALUE_RST, MAX_PAYLOAD_RST);
            default: ;
         endcase
         send_random_traffic(PHASE_ITEMS);
      end

      settle_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run took %0d requests and checked %0d responses (%0d good, %0d bad frames)",
               requests_sent, responses_seen, good_frames, bad_frames);
      $display("register settings applied: %0d, long response stall done: %0d",
               settings_applied, pressure_done);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
design/sldf_pkg.sv
design/sldf_if.sv
design/sldf_frame_fsm.sv
design/sync_length_checksum_deframer_core.sv
sim/tb_sync_length_checksum_deframer_core.sv
